[rtl/khc_pkg.sv]
// Package: shared types and constants for the key press heat map colorizer.
package khc_pkg;
    localparam int KEY_ROWS = 4;
    localparam int KEY_COLS = 16;

    typedef struct packed {
        logic       action;
        logic [1:0] key_row;
        logic [3:0] key_col;
        logic [1:0] key_flags;
    } t_in_item;

    typedef struct packed {
        logic [1:0] led_row;
        logic [3:0] led_col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_led;
    } t_out_item;

    localparam logic [15:0] COUNT_LIMIT = 16'd32767;
    localparam logic [2:0]  PAL_LEN_RST = 3'd4;
    localparam logic [23:0] COLOR0_RST  = 24'h000000;
    localparam logic [23:0] COLOR1_RST  = 24'h19FF19;
    localparam logic [23:0] COLOR2_RST  = 24'hFFFF19;
    localparam logic [23:0] COLOR3_RST  = 24'hFF1919;

    localparam logic [2:0] REG_PAL_LEN = 3'd0;
    localparam logic [2:0] REG_COLOR0  = 3'd1;
    localparam logic [2:0] REG_COLOR1  = 3'd2;
    localparam logic [2:0] REG_COLOR2  = 3'd3;
    localparam logic [2:0] REG_COLOR3  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HALVE, ST_EV_RD, ST_EV_WR, ST_RN_RD, ST_RN_DIV, ST_RN_OUT
    } t_back_state;

    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] f);
        logic [16:0] s;
        s = 17'(a) * (17'd256 - 17'(f)) + 17'(b) * 17'(f);
        return s[15:8];
    endfunction
endpackage

[rtl/key_press_heatmap_colorizer.sv]
// Top level: key press heat map colorizer with APB register port.
//  channel | signals                    | handshake
//  in      | i_start, i_item, o_busy    | accepted when start and !busy
//  out     | o_done, o_result           | one cycle per result, no stall
//  cfg     | APB psel..pready           | write on access phase, pready high
// Key event: counter read then write; render: each key goes through a bit-serial divider,
// for all 64 keys in turn. A halving sweep walks all KEY_ROWS*KEY_COLS counters.
// After reset a clearing pass writes all 2^(row bits + column bits) RAM words before items start.
// Results cannot be stalled; a two-item queue sits ahead of the back end.
module key_press_heatmap_colorizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  khc_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_done,
    output khc_pkg::t_out_item o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import khc_pkg::*;
    logic [2:0]  r_pal_len;
    logic [23:0] r_color0, r_color1, r_color2, r_color3;
    logic        w_qv, w_pop;
    t_in_item    w_qi;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_len <= PAL_LEN_RST; r_color0 <= COLOR0_RST; r_color1 <= COLOR1_RST;
            r_color2 <= COLOR2_RST; r_color3 <= COLOR3_RST;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_PAL_LEN: r_pal_len <= pwdata[2:0];
                REG_COLOR0:  r_color0 <= pwdata[23:0];
                REG_COLOR1:  r_color1 <= pwdata[23:0];
                REG_COLOR2:  r_color2 <= pwdata[23:0];
                REG_COLOR3:  r_color3 <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PAL_LEN: prdata = {29'd0, r_pal_len};
            REG_COLOR0:  prdata = {8'd0, r_color0};
            REG_COLOR1:  prdata = {8'd0, r_color1};
            REG_COLOR2:  prdata = {8'd0, r_color2};
            REG_COLOR3:  prdata = {8'd0, r_color3};
            default:     prdata = '0;
        endcase
    end

    khc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_q_valid(w_qv), .o_q_item(w_qi), .i_q_pop(w_pop)
    );

    khc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .i_q_item(w_qi),
        .o_q_pop(w_pop), .i_pal_len(r_pal_len), .i_color0(r_color0),
        .i_color1(r_color1), .i_color2(r_color2), .i_color3(r_color3),
        .o_done(o_done), .o_result(o_result)
    );
endmodule

[rtl/khc_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module khc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/khc_front.sv]
// Front end: accepts items and queues them for the back end.
module khc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  khc_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_q_valid,
    output khc_pkg::t_in_item o_q_item,
    input  logic              i_q_pop
);
    import khc_pkg::*;
    // two-entry queue
    t_in_item   r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       w_push, w_keep;

    // every item runs the halving check, so all items are queued
    assign w_keep = 1'b1;
    assign o_busy = (r_cnt == 2'd2);
    assign w_push = i_start && !o_busy && w_keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= 1'b0; r_rp <= 1'b0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

[rtl/khc_back.sv]
// Back end: counter updates, halving sweeps, and the render walk with a serial divider.
module khc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  khc_pkg::t_in_item  i_q_item,
    output logic               o_q_pop,
    input  logic [2:0]         i_pal_len,
    input  logic [23:0]        i_color0,
    input  logic [23:0]        i_color1,
    input  logic [23:0]        i_color2,
    input  logic [23:0]        i_color3,
    output logic               o_done,
    output khc_pkg::t_out_item o_result
);
    import khc_pkg::*;
    localparam int NK = KEY_ROWS * KEY_COLS;
    localparam int CW = $clog2(KEY_COLS) > 0 ? $clog2(KEY_COLS) : 1;
    localparam int RW = $clog2(KEY_ROWS) > 0 ? $clog2(KEY_ROWS) : 1;
    localparam int AW = RW + CW;

    t_back_state r_st, n_st;
    t_in_item    r_it;
    logic [AW:0] r_k;
    logic [15:0] r_max;
    logic [AW-1:0] r_clr;
    logic        r_clr_done;
    logic [4:0]  r_bit;
    logic [25:0] r_num;
    logic [16:0] r_rem;
    logic [25:0] r_quo;
    logic        r_out_v;
    t_out_item   r_out;
    logic        r_hdone;

    logic           w_we;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [15:0]    w_wdata, w_rdata;
    logic [2:0]     w_len;
    logic [1:0]     w_lm1;
    logic [AW-1:0]  w_ek;

    khc_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign w_len = (i_pal_len == 3'd0) ? 3'd1 : (i_pal_len > 3'd4) ? 3'd4 : i_pal_len;
    assign w_lm1 = 2'(w_len - 3'd1);
    assign w_ek  = AW'(r_it.key_row) * AW'(KEY_COLS) + AW'(r_it.key_col);

    wire w_ev_ok = !r_it.action && (32'(r_it.key_row) < KEY_ROWS)
                   && (32'(r_it.key_col) < KEY_COLS)
                   && r_it.key_flags[0] && !r_it.key_flags[1];
    wire [15:0] w_inc = w_rdata + 16'd1;
    wire w_need_halve = {1'b0, r_max} > 17'({w_len, 9'd0});

    // halving walk: r_k counts 0..NK reading, each word is written back in the next cycle
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (i_q_valid && r_clr_done) n_st = w_need_halve ? ST_HALVE :
                           (i_q_item.action ? ST_RN_RD : ST_EV_RD);
            ST_HALVE:  if (r_k == (AW+1)'(NK)) n_st = r_hdone ? ST_IDLE :
                           (r_it.action ? ST_RN_RD : ST_EV_RD);
            ST_EV_RD:  n_st = w_ev_ok ? ST_EV_WR : ST_IDLE;
            ST_EV_WR:  n_st = (w_inc > r_max && w_inc == COUNT_LIMIT) ? ST_HALVE : ST_IDLE;
            ST_RN_RD:  n_st = ST_RN_DIV;
            ST_RN_DIV: if (r_bit == 5'd0) n_st = ST_RN_OUT;
            ST_RN_OUT: n_st = (r_k == (AW+1)'(NK - 1)) ? ST_IDLE : ST_RN_RD;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        w_we = 1'b0; w_waddr = w_ek; w_wdata = w_inc; w_raddr = r_k[AW-1:0];
        o_q_pop = (r_st == ST_IDLE) && i_q_valid && r_clr_done;
        unique case (r_st)
            ST_IDLE:   begin
                w_we = !r_clr_done; w_waddr = r_clr; w_wdata = '0;
                w_raddr = '0;
            end
            ST_HALVE:  begin
                w_we = (r_k != '0); w_waddr = AW'(r_k - 1'b1);
                w_wdata = {1'b0, w_rdata[15:1]};
            end
            ST_EV_RD:  w_raddr = w_ek;
            ST_EV_WR:  w_we = 1'b1;
            default:   ;
        endcase
    end

    wire [16:0] w_trial = {r_rem[15:0], r_num[25]} - {1'b0, r_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_max <= 16'd1; r_clr <= '0; r_clr_done <= 1'b0;
            r_out_v <= 1'b0; r_k <= '0; r_hdone <= 1'b0;
        end else begin
            r_st <= n_st;
            r_out_v <= (r_st == ST_RN_OUT);
            if (o_q_pop) r_it <= i_q_item;
            if (r_st == ST_IDLE && !r_clr_done) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == AW'((1 << AW) - 1)) r_clr_done <= 1'b1;
            end
            unique case (r_st)
                ST_IDLE: begin
                    r_k <= '0;
                    r_hdone <= 1'b0;
                end
                ST_HALVE: begin
                    if (r_k == (AW+1)'(NK)) begin
                        r_k <= '0;
                        r_hdone <= 1'b0;
                    end else r_k <= r_k + 1'b1;
                    if (r_k == '0) r_max <= {1'b0, r_max[15:1]};
                end
                ST_EV_RD: ;
                ST_EV_WR: begin
                    if (w_inc > r_max) r_max <= w_inc;
                    r_hdone <= 1'b1;
                end
                ST_RN_RD: r_bit <= 5'd26;
                ST_RN_DIV: begin
                    if (r_bit == 5'd26) begin
                        r_num <= 26'(w_rdata) * 26'(w_lm1) << 8;
                        r_rem <= '0; r_quo <= '0;
                        r_bit <= 5'd25;
                    end else begin
                        if (!w_trial[16]) r_rem <= w_trial;
                        else r_rem <= {r_rem[15:0], r_num[25]};
                        r_quo <= {r_quo[24:0], !w_trial[16]};
                        r_num <= {r_num[24:0], 1'b0};
                        r_bit <= r_bit - 5'd1;
                    end
                end
                ST_RN_OUT: begin : out_blk
                    logic [25:0] q;
                    logic [9:0]  top, pos;
                    logic [1:0]  i1, i2;
                    logic [23:0] c1, c2;
                    logic [7:0]  f;
                    q = r_quo;
                    top = {w_lm1, 8'd0};
                    pos = (r_max == 16'd0) ? 10'd0 : (q > 26'(top)) ? top : q[9:0];
                    i1 = pos[9:8];
                    i2 = (3'(i1) + 3'd1 < w_len) ? i1 + 2'd1 : w_lm1;
                    f = pos[7:0];
                    c1 = (i1 == 2'd0) ? i_color0 : (i1 == 2'd1) ? i_color1 :
                         (i1 == 2'd2) ? i_color2 : i_color3;
                    c2 = (i2 == 2'd0) ? i_color0 : (i2 == 2'd1) ? i_color1 :
                         (i2 == 2'd2) ? i_color2 : i_color3;
                    r_k <= r_k + 1'b1;
                    r_out.led_row  <= 2'(r_k[AW-1:0] / AW'(KEY_COLS));
                    r_out.led_col  <= 4'(r_k[AW-1:0] % AW'(KEY_COLS));
                    r_out.red      <= blend(c1[23:16], c2[23:16], f);
                    r_out.green    <= blend(c1[15:8], c2[15:8], f);
                    r_out.blue     <= blend(c1[7:0], c2[7:0], f);
                    r_out.last_led <= (r_k == (AW+1)'(NK - 1));
                end
                default: ;
            endcase
        end
    end

    assign o_done = r_out_v;
    assign o_result = r_out;
endmodule

[sim/key_press_heatmap_colorizer_test.sv]
// Testbench for the key press heat map colorizer: scoreboard predictor plus directed and random items.
module key_press_heatmap_colorizer_test;
    import khc_pkg::*;

    localparam int ROWS = 4;
    localparam int COLS = 16;
    localparam int KEYS = ROWS * COLS;
    localparam int TIMEOUT = 20000;

    class heat_board;
        logic [2:0]  pal_len;
        logic [23:0] pal[4];
        logic [15:0] counts[KEYS];
        logic [15:0] top_count;
        t_out_item   pending[$];
        int          errors;

        function void clear();
            pal_len = PAL_LEN_RST;
            pal[0] = COLOR0_RST;
            pal[1] = COLOR1_RST;
            pal[2] = COLOR2_RST;
            pal[3] = COLOR3_RST;
            foreach (counts[k]) counts[k] = 16'd0;
            top_count = 16'd1;
            errors = 0;
        endfunction

        function int eff_len();
            if (pal_len < 3'd1) return 1;
            if (pal_len > 3'd4) return 4;
            return int'(pal_len);
        endfunction

        function void halve();
            foreach (counts[k]) counts[k] = counts[k] >> 1;
            top_count = top_count >> 1;
        endfunction

        function void write_reg(int idx, logic [31:0] val);
            if (idx == int'(REG_PAL_LEN)) pal_len = val[2:0];
            else pal[idx - 1] = val[23:0];
        endfunction

        function logic [7:0] mix(logic [7:0] a, logic [7:0] b, int f);
            int s;
            s = int'(a) * (256 - f) + int'(b) * f;
            return s[15:8];
        endfunction

        function void note_item(t_in_item it);
            int len, k, pos, i1, i2, f;
            logic [16:0] v;
            t_out_item o;
            len = eff_len();
            if (int'(top_count) > (len << 9)) halve();
            if (!it.action) begin
                if (it.key_flags[1] || !it.key_flags[0]) return;
                k = int'(it.key_row) * COLS + int'(it.key_col);
                v = 17'(counts[k]) + 17'd1;
                counts[k] = v[15:0];
                if (top_count < v[15:0]) begin
                    top_count = v[15:0];
                    if (v[15:0] == COUNT_LIMIT) halve();
                end
                return;
            end
            for (k = 0; k < KEYS; k++) begin
                pos = 0;
                if (top_count != 0) begin
                    pos = (int'(counts[k]) * (len - 1) * 256) / int'(top_count);
                    if (pos > (len - 1) * 256) pos = (len - 1) * 256;
                end
                i1 = (pos >> 8) & 3;
                i2 = (i1 + 1 < len) ? i1 + 1 : len - 1;
                f = pos & 255;
                o.led_row = 2'(k / COLS);
                o.led_col = 4'(k % COLS);
                o.red = mix(pal[i1][23:16], pal[i2][23:16], f);
                o.green = mix(pal[i1][15:8], pal[i2][15:8], f);
                o.blue = mix(pal[i1][7:0], pal[i2][7:0], f);
                o.last_led = (k == KEYS - 1);
                pending.push_back(o);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    t_in_item    i_item = '0;
    logic        o_busy, o_done;
    t_out_item   o_result;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    heat_board board = new();
    int idle_cycles = 0;
    bit no_gaps = 0;

    key_press_heatmap_colorizer dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (o_done) board.check_result(o_result);
        if ((i_start && !o_busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > TIMEOUT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(t_in_item it);
        while (!no_gaps && $urandom_range(99) < 12) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start <= 1;
        i_item <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_item(it);
    endtask

    task automatic key_event(int row, int col, int flags);
        t_in_item it;
        it.action = 0;
        it.key_row = 2'(row);
        it.key_col = 4'(col);
        it.key_flags = 2'(flags);
        send_item(it);
    endtask

    task automatic render();
        t_in_item it;
        it = 9'($urandom);
        it.action = 1;
        send_item(it);
    endtask

    task automatic settle();
        i_start <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= 5'(idx * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.write_reg(idx, val);
    endtask

    task automatic random_phase(int n);
        int i, r;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 8) render();
            else if (r < 80) key_event($urandom_range(1, 0) * $urandom_range(3),
                                       $urandom_range(15), 1);
            else key_event($urandom_range(3), $urandom_range(15), $urandom_range(3));
        end
        render();
        settle();
    endtask

    initial begin
        board.clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);
        render();
        key_event(0, 0, 1);
        key_event(3, 15, 1);
        key_event(3, 15, 1);
        key_event(1, 5, 0);
        key_event(1, 5, 2);
        key_event(1, 5, 3);
        key_event(2, 7, 1);
        render();
        settle();
        write_reg(REG_PAL_LEN, 1);
        write_reg(REG_COLOR0, 32'hFFFFFFFF);
        render();
        settle();
        write_reg(REG_PAL_LEN, 0);
        write_reg(REG_COLOR0, 32'h00123456);
        render();
        settle();
        write_reg(REG_PAL_LEN, 7);
        write_reg(REG_COLOR1, 32'h00FFFFFF);
        write_reg(REG_COLOR2, 32'h00000000);
        write_reg(REG_COLOR3, 32'h00A5C3E7);
        render();
        settle();
        write_reg(REG_PAL_LEN, 1);
        render();
        settle();
        write_reg(REG_PAL_LEN, 3);
        write_reg(REG_COLOR0, $urandom);
        write_reg(REG_COLOR1, $urandom);
        write_reg(REG_COLOR2, $urandom);
        random_phase(30);
        write_reg(REG_PAL_LEN, 2);
        write_reg(REG_COLOR3, $urandom);
        no_gaps = 1;
        random_phase(20);
        no_gaps = 0;
        write_reg(REG_PAL_LEN, 4);
        random_phase(30);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
